// ===== hw/rtl/spq_pkg.sv =====
// spq_pkg: shared constants, command and status codes and the cell control struct
// for the sorted priority queue. Used by spq_cell and sorted_priority_queue.
// No dependencies.
package spq_pkg;

  // default sizing
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  // fixed field widths
  localparam int PRIO_BITS    = 3;
  localparam int CMD_BITS     = 2;
  localparam int POS_BITS     = 4;
  localparam int PORT_TAG_BITS = 16;
  localparam int STATUS_BITS  = 2;
  localparam int OUT_CNT_BITS = 5;
  localparam int CFG_IDX_BITS = 1;

  // input commands
  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_PURGE  = 2'd2;

  // result status codes
  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_PRIO  = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_NOPOS = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGHEST = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PURGE   = 1'b1;

  // configuration reset values
  localparam logic [PRIO_BITS-1:0] HIGHEST_RESET = 3'd5;
  localparam logic [PRIO_BITS-1:0] PURGE_RESET   = 3'd1;

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_PURGE  = 2'd3;

  // control broadcast to every cell
  typedef struct packed {
    logic [1:0]           op;
    logic [PRIO_BITS-1:0] prio;
    logic [PRIO_BITS-1:0] purge_prio;
  } spq_ctl_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// sorted_priority_queue: insert, delete and purge on a store kept sorted by
// ascending priority. Insert, delete and unused commands act on acceptance, and
// a beat may be accepted every cycle while in_stall is low; the result is
// registered in the cycle after acceptance. Purge removes one matching entry per
// cycle through the cell chain, stalling input meanwhile. Reset (synchronous,
// active low) empties the store and sets highest priority to 5, purge priority 1.
module sorted_priority_queue #(
  parameter int DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [spq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [spq_pkg::PRIO_BITS-1:0]     cfg_wdata,
  // command channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spq_pkg::CMD_BITS-1:0]      in_command,
  input  logic [spq_pkg::PRIO_BITS-1:0]     in_priority_req,
  input  logic [spq_pkg::PORT_TAG_BITS-1:0] in_tag,
  input  logic [spq_pkg::POS_BITS-1:0]      in_position,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spq_pkg::STATUS_BITS-1:0]   out_status,
  output logic [spq_pkg::OUT_CNT_BITS-1:0]  out_entry_count,
  output logic [spq_pkg::OUT_CNT_BITS-1:0]  out_removed_count,
  output logic [spq_pkg::PORT_TAG_BITS-1:0] out_removed_tag,
  output logic [spq_pkg::PRIO_BITS-1:0]     out_head_priority,
  output logic [spq_pkg::PORT_TAG_BITS-1:0] out_head_tag
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > spq_pkg::POS_BITS) ? CW : spq_pkg::POS_BITS;
  localparam int PB = spq_pkg::PRIO_BITS;
  localparam int OTB = spq_pkg::PORT_TAG_BITS;
  localparam int OCB = spq_pkg::OUT_CNT_BITS;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PURGE = 1'b1;

  // control and configuration registers
  logic                            state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   rm_cnt_r, rm_cnt_nxt;
  logic [PB-1:0]                   highest_r;
  logic [PB-1:0]                   purge_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [spq_pkg::STATUS_BITS-1:0] out_status_r, out_status_nxt;
  logic [CW-1:0]                   out_removed_r, out_removed_nxt;
  logic [TAG_BITS-1:0]             out_rtag_r, out_rtag_nxt;

  // cell chain signals
  spq_pkg::spq_ctl_t   ctl;
  logic [PB-1:0]       prio_w  [DEPTH];
  logic [TAG_BITS-1:0] tag_w   [DEPTH];
  logic [DEPTH-1:0]    occ_w;
  logic [DEPTH-1:0]    ge_w;
  logic [DEPTH-1:0]    match_w;

  logic                accept;
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       cnt_ext;
  logic [TAG_BITS-1:0] new_tag;
  logic [TAG_BITS+OTB-1:0] new_tag_wide;
  logic [TAG_BITS-1:0] sel_tag;
  logic                any_match;
  logic                more_match;

  assign pos_ext      = PW'(in_position);
  assign cnt_ext      = PW'(count_r);
  assign new_tag_wide = (TAG_BITS + OTB)'(in_tag);
  assign new_tag      = new_tag_wide[TAG_BITS-1:0];

  // handshake
  assign in_stall = (state_r == ST_PURGE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          l_occ, l_ge;
    logic [PB-1:0] l_prio, r_prio;
    logic [TAG_BITS-1:0] l_tag, r_tag;

    if (i == 0) begin : g_first
      assign l_occ  = 1'b1;
      assign l_ge   = 1'b0;
      assign l_prio = '0;
      assign l_tag  = '0;
    end else begin : g_mid
      assign l_occ  = occ_w[i-1];
      assign l_ge   = ge_w[i-1];
      assign l_prio = prio_w[i-1];
      assign l_tag  = tag_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_prio = prio_w[i];
      assign r_tag  = tag_w[i];
    end else begin : g_inner
      assign r_prio = prio_w[i+1];
      assign r_tag  = tag_w[i+1];
    end

    spq_cell #(
      .IDX      (i),
      .CW       (CW),
      .PW       (PW),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos_ext),
      .count      (count_r),
      .new_tag    (new_tag),
      .left_occ   (l_occ),
      .left_ge    (l_ge),
      .left_prio  (l_prio),
      .left_tag   (l_tag),
      .right_prio (r_prio),
      .right_tag  (r_tag),
      .prio       (prio_w[i]),
      .tag        (tag_w[i]),
      .occ        (occ_w[i]),
      .ge         (ge_w[i]),
      .match      (match_w[i])
    );
  end

  // tag at the delete position, and purge run detection
  always_comb begin
    sel_tag    = '0;
    more_match = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (PW'(i) == pos_ext) begin
        sel_tag = sel_tag | tag_w[i];
      end
      if (i > 0) begin
        more_match = more_match | (match_w[i] & match_w[i-1]);
      end
    end
  end
  assign any_match = |match_w;

  // command sequencer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rm_cnt_nxt      = rm_cnt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_rtag_nxt    = out_rtag_r;
    ctl.op          = spq_pkg::OP_HOLD;
    ctl.prio        = in_priority_req;
    ctl.purge_prio  = purge_r;

    if (state_r == ST_PURGE) begin
      // one matching entry leaves per cycle
      ctl.op     = spq_pkg::OP_PURGE;
      count_nxt  = count_r - CW'(1);
      rm_cnt_nxt = rm_cnt_r + CW'(1);
      if (!more_match) begin
        state_nxt       = ST_IDLE;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = spq_pkg::STAT_OK;
        out_removed_nxt = rm_cnt_r + CW'(1);
        out_rtag_nxt    = '0;
      end
    end else if (accept) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = spq_pkg::STAT_OK;
      out_removed_nxt = '0;
      out_rtag_nxt    = '0;
      unique case (in_command)
        spq_pkg::CMD_INSERT: begin
          priority if (count_r == CW'(DEPTH)) begin
            out_status_nxt = spq_pkg::STAT_FULL;
          end else if (in_priority_req > highest_r) begin
            out_status_nxt = spq_pkg::STAT_PRIO;
          end else begin
            ctl.op    = spq_pkg::OP_INSERT;
            count_nxt = count_r + CW'(1);
          end
        end
        spq_pkg::CMD_DELETE: begin
          if (pos_ext >= cnt_ext) begin
            out_status_nxt = spq_pkg::STAT_NOPOS;
          end else begin
            ctl.op          = spq_pkg::OP_DELETE;
            count_nxt       = count_r - CW'(1);
            out_removed_nxt = CW'(1);
            out_rtag_nxt    = sel_tag;
          end
        end
        spq_pkg::CMD_PURGE: begin
          if (any_match) begin
            ctl.op          = spq_pkg::OP_PURGE;
            count_nxt       = count_r - CW'(1);
            out_removed_nxt = CW'(1);
            if (more_match) begin
              state_nxt     = ST_PURGE;
              rm_cnt_nxt    = CW'(1);
              out_valid_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rm_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      highest_r   <= spq_pkg::HIGHEST_RESET;
      purge_r     <= spq_pkg::PURGE_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rm_cnt_r    <= rm_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          spq_pkg::CFG_HIGHEST: highest_r <= cfg_wdata;
          spq_pkg::CFG_PURGE:   purge_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_rtag_r    <= out_rtag_nxt;
  end

  // result fields; head and count are read live since the store holds
  // still while a result beat waits
  logic [CW+OCB-1:0]      cnt_wide;
  logic [CW+OCB-1:0]      rm_wide;
  logic [TAG_BITS+OTB-1:0] rtag_wide;
  logic [TAG_BITS+OTB-1:0] head_wide;

  assign cnt_wide  = (CW + OCB)'(count_r);
  assign rm_wide   = (CW + OCB)'(out_removed_r);
  assign rtag_wide = (TAG_BITS + OTB)'(out_rtag_r);
  assign head_wide = (count_r != '0) ? (TAG_BITS + OTB)'(tag_w[0]) : '0;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = cnt_wide[OCB-1:0];
  assign out_removed_count = rm_wide[OCB-1:0];
  assign out_removed_tag   = rtag_wide[OTB-1:0];
  assign out_head_priority = (count_r != '0) ? prio_w[0] : '0;
  assign out_head_tag      = head_wide[OTB-1:0];

endmodule

// ===== hw/rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted store; holds a priority and a tag and takes
// its next contents from itself, its left or right neighbor, or the new entry.
// Depends on spq_pkg.
module spq_cell #(
  parameter int IDX      = 0,
  parameter int CW       = 5,
  parameter int PW       = 5,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  spq_pkg::spq_ctl_t             ctl,
  input  logic [PW-1:0]                 pos,
  input  logic [CW-1:0]                 count,
  input  logic [TAG_BITS-1:0]           new_tag,
  input  logic                          left_occ,
  input  logic                          left_ge,
  input  logic [spq_pkg::PRIO_BITS-1:0] left_prio,
  input  logic [TAG_BITS-1:0]           left_tag,
  input  logic [spq_pkg::PRIO_BITS-1:0] right_prio,
  input  logic [TAG_BITS-1:0]           right_tag,
  output logic [spq_pkg::PRIO_BITS-1:0] prio,
  output logic [TAG_BITS-1:0]           tag,
  output logic                          occ,
  output logic                          ge,
  output logic                          match
);

  logic [spq_pkg::PRIO_BITS-1:0] prio_r;
  logic [spq_pkg::PRIO_BITS-1:0] prio_nxt;
  logic [TAG_BITS-1:0]           tag_r;
  logic [TAG_BITS-1:0]           tag_nxt;
  logic                          at_end;

  // slot status against the fill count
  assign occ    = CW'(IDX) < count;
  assign ge     = occ && (prio_r >= ctl.prio);
  assign match  = occ && (prio_r == ctl.purge_prio);
  assign at_end = !occ && left_occ;

  assign prio = prio_r;
  assign tag  = tag_r;

  // next slot contents
  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    unique case (ctl.op)
      spq_pkg::OP_HOLD: begin
      end
      spq_pkg::OP_INSERT: begin
        priority if (left_ge) begin
          prio_nxt = left_prio;
          tag_nxt  = left_tag;
        end else if (ge || at_end) begin
          prio_nxt = ctl.prio;
          tag_nxt  = new_tag;
        end
      end
      spq_pkg::OP_DELETE: begin
        if (PW'(IDX) >= pos) begin
          prio_nxt = right_prio;
          tag_nxt  = right_tag;
        end
      end
      spq_pkg::OP_PURGE: begin
        // the matching run is contiguous; it and everything after it moves up
        if (!occ || (prio_r >= ctl.purge_prio)) begin
          prio_nxt = right_prio;
          tag_nxt  = right_tag;
        end
      end
      default: begin
      end
    endcase
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

endmodule
